// ----- design/bfth_pkg.sv -----
// Shared types and constants for the three-hash Bloom filter.
// Used by bfth_hash and bloom_filter_three_hash_top; no dependencies.
package bfth_pkg;

  // Default filter size in bits
  localparam int MAX_BITS_DEF = 128;

  // Field widths
  localparam int CHAR_W     = 7;
  localparam int BITS_W     = 8;
  localparam int HASH_W     = 4;
  localparam int RES_W      = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 4'd1;

  // Register reset values
  localparam logic [BITS_W-1:0] BIT_COUNT_RST  = 8'd128;
  localparam logic [HASH_W-1:0] HASH_COUNT_RST = 4'd3;

  // Request types
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Residue moduli
  localparam logic [8:0] MOD_PLAIN  = 9'd101;
  localparam logic [8:0] MOD_WEIGHT = 9'd103;
  localparam logic [8:0] MOD_SQUARE = 9'd107;

  // Hash unit sequencer
  typedef enum logic [1:0] {
    H_IDLE,
    H_CHAR,
    H_DIV,
    H_DONE
  } hash_state_t;

  // Top-level control sequencer
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_CHECK,
    S_REPLY
  } ctl_state_t;

  // Start of work for the hash unit
  typedef struct packed {
    logic go;
    logic char_valid;
    logic last_char;
  } hash_req_t;

  // Hash unit status back to control
  typedef struct packed {
    logic done;
    logic key_end;
  } hash_stat_t;

endpackage

// ----- design/bfth_hash.sv -----
// Running residues and probe positions for the three-hash Bloom filter.
// Bit-serial multiply-mod per character and restoring remainder at key end.
// Depends on bfth_pkg.
module bfth_hash #(
  parameter int MAX_BITS = bfth_pkg::MAX_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bfth_pkg::hash_req_t         req,
  input  logic [bfth_pkg::CHAR_W-1:0] char_code,
  input  logic [bfth_pkg::BITS_W-1:0] bits_m,
  output bfth_pkg::hash_stat_t        stat,
  output logic [$clog2(MAX_BITS)-1:0] pos_a,
  output logic [$clog2(MAX_BITS)-1:0] pos_b,
  output logic [$clog2(MAX_BITS)-1:0] pos_c
);

  localparam int AW = $clog2(MAX_BITS);
  localparam int RW = bfth_pkg::RES_W;
  localparam int BW = bfth_pkg::BITS_W;
  localparam logic [2:0] LAST_STEP = 3'd6;

  // x < 3*m, returns x mod m
  function automatic logic [RW-1:0] mod_lt3(input logic [8:0] x, input logic [8:0] m);
    logic [8:0] r;
    if (x >= (m << 1)) begin
      r = x - (m << 1);
    end else if (x >= m) begin
      r = x - m;
    end else begin
      r = x;
    end
    return r[RW-1:0];
  endfunction

  // One restoring remainder step: (2*rem + b) mod m, rem < m
  function automatic logic [BW-1:0] rem_step(input logic [BW-1:0] rem, input logic b,
                                             input logic [BW-1:0] m);
    logic [BW:0] t;
    t = {rem, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[BW-1:0];
  endfunction

  bfth_pkg::hash_state_t state_r, state_nxt;
  logic [2:0]    step_r;
  logic [RW-1:0] c_r;
  logic          valid_r;
  logic          last_r;
  logic [RW-1:0] pres_r, wres_r, sres_r;
  logic [RW-1:0] p1_r, p2_r, sq_r;
  logic [RW-1:0] accw_r, accs_r;
  logic [BW-1:0] rema_r, remb_r, remc_r;

  logic [2:0]    bit_idx;
  logic          cbit;
  logic [RW-1:0] accw_in, accs_in;
  logic [RW-1:0] accw_nxt, accs_nxt;
  logic [BW-1:0] rem_a_in, rem_b_in, rem_c_in;
  logic [BW-1:0] rema_nxt, remb_nxt, remc_nxt;
  logic [RW-1:0] pres_upd, wres_upd, sres_upd;
  logic [RW-1:0] p1_upd, p2_upd, sq_upd;
  logic          step_end;

  assign bit_idx  = LAST_STEP - step_r;
  assign step_end = (step_r == LAST_STEP);
  assign cbit     = c_r[bit_idx];

  // Horner step of c*p mod M, MSB of c first
  always_comb begin
    accw_in  = (step_r == 3'd0) ? '0 : accw_r;
    accs_in  = (step_r == 3'd0) ? '0 : accs_r;
    accw_nxt = mod_lt3({1'b0, accw_in, 1'b0} + (cbit ? 9'(p1_r) : 9'd0),
                       bfth_pkg::MOD_WEIGHT);
    accs_nxt = mod_lt3({1'b0, accs_in, 1'b0} + (cbit ? 9'(sq_r) : 9'd0),
                       bfth_pkg::MOD_SQUARE);
  end

  // Residue and position updates at the last character step
  always_comb begin
    pres_upd = mod_lt3(9'(pres_r) + 9'(c_r), bfth_pkg::MOD_PLAIN);
    wres_upd = mod_lt3(9'(wres_r) + 9'(accw_nxt), bfth_pkg::MOD_WEIGHT);
    sres_upd = mod_lt3(9'(sres_r) + 9'(accs_nxt), bfth_pkg::MOD_SQUARE);
    p1_upd   = (p1_r == RW'(bfth_pkg::MOD_WEIGHT - 9'd1)) ? '0 : p1_r + 1'b1;
    p2_upd   = (p2_r == RW'(bfth_pkg::MOD_SQUARE - 9'd1)) ? '0 : p2_r + 1'b1;
    // (p+1)^2 = p^2 + 2p + 1
    sq_upd   = mod_lt3(9'(sq_r) + {1'b0, p2_r, 1'b0} + 9'd1, bfth_pkg::MOD_SQUARE);
  end

  // Remainder of each residue by the filter size, one bit per step
  always_comb begin
    rem_a_in = (step_r == 3'd0) ? '0 : rema_r;
    rem_b_in = (step_r == 3'd0) ? '0 : remb_r;
    rem_c_in = (step_r == 3'd0) ? '0 : remc_r;
    rema_nxt = rem_step(rem_a_in, pres_r[bit_idx], bits_m);
    remb_nxt = rem_step(rem_b_in, wres_r[bit_idx], bits_m);
    remc_nxt = rem_step(rem_c_in, sres_r[bit_idx], bits_m);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfth_pkg::H_IDLE: begin
        if (req.go) begin
          if (req.char_valid) begin
            state_nxt = bfth_pkg::H_CHAR;
          end else if (req.last_char) begin
            state_nxt = bfth_pkg::H_DIV;
          end else begin
            state_nxt = bfth_pkg::H_DONE;
          end
        end
      end
      bfth_pkg::H_CHAR: begin
        if (step_end) begin
          state_nxt = last_r ? bfth_pkg::H_DIV : bfth_pkg::H_DONE;
        end
      end
      bfth_pkg::H_DIV: begin
        if (step_end) begin
          state_nxt = bfth_pkg::H_DONE;
        end
      end
      bfth_pkg::H_DONE: state_nxt = bfth_pkg::H_IDLE;
      default:          state_nxt = bfth_pkg::H_IDLE;
    endcase
  end

  // Status outputs
  always_comb begin
    stat.done    = (state_r == bfth_pkg::H_DONE);
    stat.key_end = (state_r == bfth_pkg::H_DONE) && last_r;
  end

  assign pos_a = AW'(rema_r);
  assign pos_b = AW'(remb_r);
  assign pos_c = AW'(remc_r);

  // Control registers and residues
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfth_pkg::H_IDLE;
      step_r  <= '0;
      pres_r  <= '0;
      wres_r  <= '0;
      sres_r  <= '0;
      p1_r    <= RW'(1);
      p2_r    <= RW'(1);
      sq_r    <= RW'(1);
    end else begin
      state_r <= state_nxt;
      if (state_r == bfth_pkg::H_CHAR || state_r == bfth_pkg::H_DIV) begin
        step_r <= step_end ? 3'd0 : step_r + 3'd1;
      end
      if (state_r == bfth_pkg::H_CHAR && step_end) begin
        pres_r <= pres_upd;
        wres_r <= wres_upd;
        sres_r <= sres_upd;
        p1_r   <= p1_upd;
        p2_r   <= p2_upd;
        sq_r   <= sq_upd;
      end
      // key done: start the next key fresh
      if (state_r == bfth_pkg::H_DIV && step_end) begin
        pres_r <= '0;
        wres_r <= '0;
        sres_r <= '0;
        p1_r   <= RW'(1);
        p2_r   <= RW'(1);
        sq_r   <= RW'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == bfth_pkg::H_IDLE && req.go) begin
      c_r     <= char_code;
      valid_r <= req.char_valid;
      last_r  <= req.last_char;
    end
    if (state_r == bfth_pkg::H_CHAR && valid_r) begin
      accw_r <= accw_nxt;
      accs_r <= accs_nxt;
    end
    if (state_r == bfth_pkg::H_DIV) begin
      rema_r <= rema_nxt;
      remb_r <= remb_nxt;
      remc_r <= remc_nxt;
    end
  end

endmodule

// ----- design/bloom_filter_three_hash_top.sv -----
// Top level of the three-hash Bloom filter: control, filter bit memory, output register.
// Depends on bfth_pkg and bfth_hash.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------------
//   in_     | in        | in_valid/in_stall  | req_type, char_code, char_valid, last_char
//   out_    | out       | out_valid/out_stall| found (lookup at key end only)
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An item with a character runs 7 serial multiply-mod steps in bfth_hash; one without
// skips them. A final item adds 7 remainder steps plus hash_count probes on the single
// memory port, then check and reply states for a lookup (reply only if hash_count is 0).
// After a synchronous reset a clearing pass writes MAX_BITS zeros, one per cycle.
// A waiting result sits in the output register; the next item is taken meanwhile,
// but the next lookup answer keeps in_stall high until that register frees up.
module bloom_filter_three_hash_top #(
  parameter int MAX_BITS = bfth_pkg::MAX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [bfth_pkg::CHAR_W-1:0]     in_char_code,
  input  logic                            in_char_valid,
  input  logic                            in_last_char,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_found,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfth_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfth_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_BITS);
  localparam int BW = bfth_pkg::BITS_W;
  localparam int HW = bfth_pkg::HASH_W;
  localparam int MCAP = (MAX_BITS > 255) ? 255 : MAX_BITS;
  localparam logic [BW-1:0] MCAP_V = BW'(MCAP);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BITS - 1);

  bfth_pkg::ctl_state_t state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          req_r, req_nxt;
  logic [HW-1:0] probe_idx_r, probe_idx_nxt;
  logic          chk_r, chk_nxt;
  logic          all_set_r, all_set_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r, out_found_nxt;
  logic [BW-1:0] bit_count_r, bit_count_nxt;
  logic [HW-1:0] hash_count_r, hash_count_nxt;

  logic          filter_bits_r [MAX_BITS];
  logic          rd_bit_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic          mem_wd;
  logic [AW-1:0] probe_pos;

  logic          in_take;
  logic          out_free;
  logic [BW-1:0] bits_m;
  bfth_pkg::hash_req_t  hreq;
  bfth_pkg::hash_stat_t hstat;
  logic [AW-1:0] pos_a, pos_b, pos_c;

  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign cfg_ready = rst_n;

  // Effective filter size: zero reads as one, saturate at the memory size (at most 255)
  always_comb begin
    if (bit_count_r == '0) begin
      bits_m = BW'(1);
    end else if (bit_count_r > MCAP_V) begin
      bits_m = MCAP_V;
    end else begin
      bits_m = bit_count_r;
    end
  end

  // Hash unit
  always_comb begin
    hreq.go         = (state_r == bfth_pkg::S_IDLE) && in_take;
    hreq.char_valid = in_char_valid;
    hreq.last_char  = in_last_char;
  end

  bfth_hash #(
    .MAX_BITS (MAX_BITS)
  ) u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (hreq),
    .char_code (in_char_code),
    .bits_m    (bits_m),
    .stat      (hstat),
    .pos_a     (pos_a),
    .pos_b     (pos_b),
    .pos_c     (pos_c)
  );

  // Probe index to bit position; indices past three probe bit zero
  always_comb begin
    case (probe_idx_r)
      4'd1:    probe_pos = pos_a;
      4'd2:    probe_pos = pos_b;
      4'd3:    probe_pos = pos_c;
      default: probe_pos = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfth_pkg::S_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = bfth_pkg::S_IDLE;
        end
      end
      bfth_pkg::S_IDLE: begin
        if (in_take) begin
          state_nxt = bfth_pkg::S_HASH;
        end
      end
      bfth_pkg::S_HASH: begin
        if (hstat.done) begin
          if (!hstat.key_end) begin
            state_nxt = bfth_pkg::S_IDLE;
          end else if (hash_count_r == '0) begin
            state_nxt = (req_r == bfth_pkg::REQ_LOOKUP) ? bfth_pkg::S_REPLY
                                                        : bfth_pkg::S_IDLE;
          end else begin
            state_nxt = bfth_pkg::S_PROBE;
          end
        end
      end
      bfth_pkg::S_PROBE: begin
        if (probe_idx_r == hash_count_r) begin
          state_nxt = (req_r == bfth_pkg::REQ_LOOKUP) ? bfth_pkg::S_CHECK
                                                      : bfth_pkg::S_IDLE;
        end
      end
      bfth_pkg::S_CHECK: state_nxt = bfth_pkg::S_REPLY;
      bfth_pkg::S_REPLY: begin
        if (out_free) begin
          state_nxt = bfth_pkg::S_IDLE;
        end
      end
      default: state_nxt = bfth_pkg::S_CLEAR;
    endcase
  end

  // State outputs: stall and memory write port
  always_comb begin
    in_stall = !rst_n || (state_r != bfth_pkg::S_IDLE);
    mem_we   = 1'b0;
    mem_wa   = probe_pos;
    mem_wd   = 1'b1;
    case (state_r)
      bfth_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr_r;
        mem_wd = 1'b0;
      end
      bfth_pkg::S_PROBE: begin
        mem_we = (req_r == bfth_pkg::REQ_INSERT);
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Datapath and configuration next values
  always_comb begin
    clr_addr_nxt   = clr_addr_r;
    req_nxt        = req_r;
    probe_idx_nxt  = probe_idx_r;
    all_set_nxt    = all_set_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_found_nxt  = out_found_r;
    bit_count_nxt  = bit_count_r;
    hash_count_nxt = hash_count_r;
    chk_nxt        = (state_r == bfth_pkg::S_PROBE) && (req_r == bfth_pkg::REQ_LOOKUP);

    if (state_r == bfth_pkg::S_CLEAR) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
    end
    if (state_r == bfth_pkg::S_IDLE && in_take) begin
      req_nxt = in_req_type;
    end
    // fold in the bit read last cycle
    if (chk_r && !rd_bit_r) begin
      all_set_nxt = 1'b0;
    end
    if (state_r == bfth_pkg::S_HASH && hstat.done) begin
      probe_idx_nxt = HW'(1);
      all_set_nxt   = 1'b1;
    end
    if (state_r == bfth_pkg::S_PROBE) begin
      probe_idx_nxt = probe_idx_r + 1'b1;
    end
    if (state_r == bfth_pkg::S_REPLY && out_free) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = all_set_r;
    end
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bfth_pkg::REG_BIT_COUNT:  bit_count_nxt  = cfg_data[BW-1:0];
        bfth_pkg::REG_HASH_COUNT: hash_count_nxt = cfg_data[HW-1:0];
        default:                  bit_count_nxt  = bit_count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bfth_pkg::S_CLEAR;
      clr_addr_r   <= '0;
      chk_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      probe_idx_r  <= '0;
      bit_count_r  <= bfth_pkg::BIT_COUNT_RST;
      hash_count_r <= bfth_pkg::HASH_COUNT_RST;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      chk_r        <= chk_nxt;
      out_valid_r  <= out_valid_nxt;
      probe_idx_r  <= probe_idx_nxt;
      bit_count_r  <= bit_count_nxt;
      hash_count_r <= hash_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    all_set_r   <= all_set_nxt;
    out_found_r <= out_found_nxt;
  end

  // Filter bit memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      filter_bits_r[mem_wa] <= mem_wd;
    end
    rd_bit_r <= filter_bits_r[probe_pos];
  end

endmodule

// ----- design/bfth_checker.sv -----
// Port-level checks for bloom_filter_three_hash_top, attached with bind.
// Sees only the top level's ports; no package dependency.
module bfth_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_found
);

  // Reset always starts the clearing pass, so no request is taken right after
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken right after reset");

  // Every request leaves the block busy in the following cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a request");

  // A result only shows up while the block is working on a request
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared from an idle block");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found))
    else $error("stalled result changed");

endmodule

bind bloom_filter_three_hash_top bfth_checker u_bfth_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_found (out_found)
);

// ----- test/testbench.sv -----
// Testbench for bloom_filter_three_hash_top: directed and random key streams with a
// self-checking bit-store predictor. Depends on bfth_pkg and the design sources only.
`timescale 1ns / 1ps

module testbench;

  localparam int CHAR_W     = bfth_pkg::CHAR_W;
  localparam int CFG_IDX_W  = bfth_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = bfth_pkg::CFG_DATA_W;
  localparam int RES_W      = bfth_pkg::RES_W;
  localparam int BITS_W     = bfth_pkg::BITS_W;
  localparam int HASH_W     = bfth_pkg::HASH_W;

  localparam int FILTER_BITS  = bfth_pkg::MAX_BITS_DEF;
  localparam int IDLE_PAUSE   = 80;      // > worst key-end work: hash, remainder, up to 15 probes, check and reply
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int BANK_SLOTS   = 16;
  localparam int KEY_MAX      = 256;

  // Register indexes with nothing behind them
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 4'hF;

  // DUT ports
  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic                  in_req_type   = bfth_pkg::REQ_INSERT;
  logic [CHAR_W-1:0]     in_char_code  = '0;
  logic                  in_char_valid = 1'b0;
  logic                  in_last_char  = 1'b0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic                  out_found;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  // Predicted filter state and configuration
  logic [FILTER_BITS-1:0] filter_store = '0;
  logic [RES_W-1:0]       sum_res      = '0;
  logic [RES_W-1:0]       wsum_res     = '0;
  logic [RES_W-1:0]       sqsum_res    = '0;
  logic [RES_W-1:0]       pos_w        = 7'd1;
  logic [RES_W-1:0]       pos_sq       = 7'd1;
  logic [BITS_W-1:0]      bits_cfg     = bfth_pkg::BIT_COUNT_RST;
  logic [HASH_W-1:0]      hashes_cfg   = bfth_pkg::HASH_COUNT_RST;

  // Lookup answers still owed by the DUT
  logic found_q[$];
  logic exp_found;

  // Key buffer and bank of inserted keys for replayed lookups
  logic [CHAR_W-1:0] key_buf [KEY_MAX];
  logic [CHAR_W-1:0] bank_chars [BANK_SLOTS][KEY_MAX];
  int                bank_len [BANK_SLOTS];
  int                bank_count = 0;

  int fails       = 0;
  int items_sent  = 0;
  int cycle_count = 0;
  bit quiet       = 1'b0;   // no idling on either side while set

  bloom_filter_three_hash_top #(
    .MAX_BITS(FILTER_BITS)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_char_code (in_char_code),
    .in_char_valid(in_char_valid),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_found    (out_found),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Random back-pressure on the result side
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 6);
  end

  // Compare each accepted result with the oldest predicted answer
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (found_q.size() == 0) begin
        $error("found: expected none, actual %0b", out_found);
        fails++;
      end else begin
        exp_found = found_q.pop_front();
        if (out_found !== exp_found) begin
          $error("found: expected %0b, actual %0b", exp_found, out_found);
          fails++;
        end
      end
    end
  end

  // Advance the predicted filter by one accepted request
  function automatic void predict_item(logic req, logic [CHAR_W-1:0] c, logic cv, logic last);
    int     sq;
    int     m;
    int     idx;
    int     pos;
    logic   all_set;
    if (cv) begin
      sq        = (int'(pos_sq) * int'(pos_sq)) % int'(bfth_pkg::MOD_SQUARE);
      sum_res   = RES_W'((int'(sum_res) + int'(c)) % int'(bfth_pkg::MOD_PLAIN));
      wsum_res  = RES_W'((int'(wsum_res) + int'(c) * int'(pos_w))
                         % int'(bfth_pkg::MOD_WEIGHT));
      sqsum_res = RES_W'((int'(sqsum_res) + int'(c) * sq) % int'(bfth_pkg::MOD_SQUARE));
      pos_w     = RES_W'((int'(pos_w) + 1) % int'(bfth_pkg::MOD_WEIGHT));
      pos_sq    = RES_W'((int'(pos_sq) + 1) % int'(bfth_pkg::MOD_SQUARE));
    end
    if (last) begin
      // zero size acts as one bit, oversize saturates
      m = (bits_cfg == '0) ? 1 : ((int'(bits_cfg) > FILTER_BITS) ? FILTER_BITS : int'(bits_cfg));
      all_set = 1'b1;
      for (idx = 1; idx <= int'(hashes_cfg); idx++) begin
        case (idx)
          1:       pos = int'(sum_res) % m;
          2:       pos = int'(wsum_res) % m;
          3:       pos = int'(sqsum_res) % m;
          default: pos = 0;
        endcase
        if (req == bfth_pkg::REQ_INSERT) filter_store[pos] = 1'b1;
        else if (!filter_store[pos]) all_set = 1'b0;
      end
      if (req == bfth_pkg::REQ_LOOKUP) found_q.push_back(all_set);
      sum_res   = '0;
      wsum_res  = '0;
      sqsum_res = '0;
      pos_w     = 7'd1;
      pos_sq    = 7'd1;
    end
  endfunction

  // Send one request; valid stays high after acceptance for the caller to reuse
  task automatic send_item(input logic req, input logic [CHAR_W-1:0] c, input logic cv,
                           input logic last);
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_char_code  <= c;
    in_char_valid <= cv;
    in_last_char  <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_item(req, c, cv, last);
    if (cv || last) items_sent++;
  endtask

  // Stream key_buf[0..len-1]; sometimes ends on a blank item, sprinkles blank fillers
  task automatic send_key(input logic req, input int len);
    int i;
    bit end_blank;
    end_blank = (len == 0) || ($urandom_range(9) == 0);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0)
        send_item(1'($urandom_range(1)), CHAR_W'($urandom_range(127)), 1'b0, 1'b0);
      if (!end_blank && i == len - 1)
        send_item(req, key_buf[i], 1'b1, 1'b1);
      else
        send_item(1'($urandom_range(1)), key_buf[i], 1'b1, 1'b0);
    end
    if (end_blank) send_item(req, CHAR_W'($urandom_range(127)), 1'b0, 1'b1);
  endtask

  // Drain: all answers in, then give the last insert time to finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (found_q.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == bfth_pkg::REG_BIT_COUNT) bits_cfg = data;
    else if (idx == bfth_pkg::REG_HASH_COUNT) hashes_cfg = data[HASH_W-1:0];
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] bits_val,
                            input logic [CFG_DATA_W-1:0] hash_val);
    wait_idle();
    write_reg(bfth_pkg::REG_BIT_COUNT, bits_val);
    write_reg(bfth_pkg::REG_HASH_COUNT, hash_val);
    cfg_valid <= 1'b0;
  endtask

  // Empty keys probe bit 0 only
  task automatic test_empty_keys();
    send_item(bfth_pkg::REQ_LOOKUP, 7'h00, 1'b0, 1'b1);
    send_item(bfth_pkg::REQ_INSERT, 7'h7F, 1'b0, 1'b1);
    send_item(bfth_pkg::REQ_LOOKUP, 7'h55, 1'b0, 1'b1);
  endtask

  // Character extremes, blank filler mid-key, request type taken from the last item
  task automatic test_char_extremes();
    send_item(bfth_pkg::REQ_LOOKUP, 7'h7F, 1'b1, 1'b0);
    send_item(bfth_pkg::REQ_LOOKUP, 7'h00, 1'b0, 1'b0);
    send_item(bfth_pkg::REQ_LOOKUP, 7'h00, 1'b1, 1'b0);
    send_item(bfth_pkg::REQ_INSERT, 7'h7F, 1'b1, 1'b1);
    send_item(bfth_pkg::REQ_INSERT, 7'h7F, 1'b1, 1'b0);
    send_item(bfth_pkg::REQ_INSERT, 7'h00, 1'b1, 1'b0);
    send_item(bfth_pkg::REQ_LOOKUP, 7'h7F, 1'b1, 1'b1);
    send_item(bfth_pkg::REQ_INSERT, 7'h00, 1'b1, 1'b0);
    send_item(bfth_pkg::REQ_INSERT, 7'h7F, 1'b1, 1'b0);
    send_item(bfth_pkg::REQ_LOOKUP, 7'h2A, 1'b0, 1'b1);
  endtask

  // Size zero acts as one bit; size above the store saturates
  task automatic test_bit_count_limits();
    set_config(8'd0, 8'd3);
    send_item(bfth_pkg::REQ_LOOKUP, 7'd42, 1'b1, 1'b1);
    set_config(8'hFF, 8'd3);
    send_item(bfth_pkg::REQ_LOOKUP, 7'h7F, 1'b1, 1'b1);
    send_item(bfth_pkg::REQ_INSERT, 7'h7F, 1'b1, 1'b1);
    send_item(bfth_pkg::REQ_LOOKUP, 7'h7F, 1'b1, 1'b1);
  endtask

  // No probes: lookup hits, insert is a no-op; beyond three probes land on bit 0
  task automatic test_hash_count_limits();
    set_config(8'd128, 8'd0);
    send_item(bfth_pkg::REQ_LOOKUP, 7'd9, 1'b1, 1'b1);
    send_item(bfth_pkg::REQ_INSERT, 7'd9, 1'b1, 1'b1);
    set_config(8'd128, 8'hFF);
    send_item(bfth_pkg::REQ_LOOKUP, 7'd1, 1'b1, 1'b1);
  endtask

  // Writes to unused indexes must leave the registers alone
  task automatic test_unknown_register();
    wait_idle();
    write_reg(REG_UNMAPPED_HI, 8'h00);
    write_reg(REG_UNMAPPED_LO, 8'h01);
    cfg_valid <= 1'b0;
    send_item(bfth_pkg::REQ_LOOKUP, 7'd1, 1'b1, 1'b1);
  endtask

  // Phases of random keys under varying sizes; lookups often replay inserted keys
  task automatic test_random_traffic();
    int   goal;
    int   phase_end;
    int   phase;
    int   len;
    int   slot;
    int   i;
    logic req;
    logic [CFG_DATA_W-1:0] bits_val;
    logic [CFG_DATA_W-1:0] hash_val;
    goal  = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < goal) begin
      case (phase)
        0: begin bits_val = 8'hFF; hash_val = 8'h08; end
        1: begin bits_val = 8'd1;  hash_val = 8'hF3; end
        2: begin bits_val = 8'd128; hash_val = 8'd3; end
        default: begin
          case ($urandom_range(7))
            0: bits_val = 8'd0;
            1: bits_val = 8'd2;
            2: bits_val = 8'd127;
            3: bits_val = 8'd129;
            default: bits_val = CFG_DATA_W'($urandom_range(255));
          endcase
          hash_val = CFG_DATA_W'($urandom_range(255));
          if ($urandom_range(1)) hash_val[HASH_W-1:0] = HASH_W'($urandom_range(1, 4));
        end
      endcase
      set_config(bits_val, hash_val);
      quiet     = (phase == 3);
      phase_end = items_sent + RANDOM_ITEMS / 8;
      while (items_sent < phase_end && items_sent < goal) begin
        req = 1'($urandom_range(1));
        if (req == bfth_pkg::REQ_LOOKUP && bank_count > 0 && $urandom_range(1)) begin
          slot = $urandom_range((bank_count < BANK_SLOTS ? bank_count : BANK_SLOTS) - 1);
          len  = bank_len[slot];
          for (i = 0; i < len; i++) key_buf[i] = bank_chars[slot][i];
        end else begin
          // long keys wrap the position counters
          len = ($urandom_range(29) == 0) ? $urandom_range(104, 230) : $urandom_range(0, 10);
          for (i = 0; i < len; i++) begin
            case ($urandom_range(7))
              0:       key_buf[i] = 7'h00;
              1:       key_buf[i] = 7'h7F;
              default: key_buf[i] = CHAR_W'($urandom_range(127));
            endcase
          end
        end
        send_key(req, len);
        if (req == bfth_pkg::REQ_INSERT) begin
          slot = bank_count % BANK_SLOTS;
          bank_len[slot] = len;
          for (i = 0; i < len; i++) bank_chars[slot][i] = key_buf[i];
          bank_count++;
        end
      end
      quiet = 1'b0;
      phase++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_keys();
    test_char_extremes();
    test_bit_count_limits();
    test_hash_count_limits();
    test_unknown_register();
    test_random_traffic();
    wait_idle();
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
design/bfth_pkg.sv
design/bfth_hash.sv
design/bloom_filter_three_hash_top.sv
design/bfth_checker.sv
test/testbench.sv
